@@ hw/rtl/batch_recoder_ring_buffer_core_macros.svh @@
// assertion macros shared by the batch recoder ring buffer rtl
`ifndef BATCH_RECODER_RING_BUFFER_CORE_MACROS_SVH
`define BATCH_RECODER_RING_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define BRRB_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("brrb assertion failed");
// next-cycle implication, checked outside reset
`define BRRB_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("brrb assertion failed");
`else
`define BRRB_ASSERT_IMP(name, ck, rn, ante, cons)
`define BRRB_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

@@ hw/rtl/brrb_pkg.sv @@
// shared types, constants and helpers of the batch recoder ring buffer
`timescale 1ns / 1ps
package brrb_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int MAX_RES  = 16;
  localparam int LIST_MAX = (DEPTH < MAX_RES) ? DEPTH : MAX_RES;
  localparam int HIT_W    = $clog2(LIST_MAX + 1);
  localparam int ID_W     = 16;
  localparam int SLOT_W   = 4;
  localparam int WIDE_W   = SLOT_W + IDX_W;
  localparam int SENT_W   = 8;

  localparam logic [SENT_W-1:0] QUOTA_RESET = 8'd16;
  localparam logic [SENT_W-1:0] SENT_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_MEMBER  = 2'd1,
    ST_REFUSED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RX_FIRST,
    OP_RX_PLAIN,
    OP_RX_FULL,
    OP_RX_CHK,
    OP_REFUSE,
    OP_SW_START,
    OP_SW_STEP,
    OP_LS_START,
    OP_LS_STEP,
    OP_LS_FIN
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RX_CHK,
    S_SW,
    S_LS_INIT,
    S_LS,
    S_LS_FIN
  } state_t;

  typedef struct packed {
    logic have_batch;
    logic ring_full;
    logic quota_met;
    logic mixed;
    logic sw_exit;
    logic ls_end;
  } dp_status_t;

  // (base + off) mod DEPTH, off below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // slot index as seen on the result port
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/batch_recoder_ring_buffer_core.sv @@
// top level of the batch recoder ring buffer core
// usage:
//   input channel: drive in_kind / in_batch_id with start high; the request is
//   taken at a clock edge where busy is low. in_kind 0 stores a received packet's
//   batch number, in_kind 1 asks for a recode run over the current send batch.
//   result channel: each result shows for one cycle with out_strobe high; there
//   is no backpressure, the receiver must take every result as it appears.
//   configuration: cfg_wr_en / cfg_wr_data write the batch quota (reset 16);
//   write only while busy is low and no result is still due.
// request handling:
//   receive: result in the cycle after the request; a full ring goes through S_RX_CHK
//   first (the slot behind the overwritten one is read back from the slot ram).
//   refused recode: one result, in the cycle after the request.
//   recode run: the listing compares one slot per cycle
//   on the single read port of the slot ram; a batch switch scan (S_SW) may run
//   ahead of it. Members stream one per cycle where adjacent.
// reset: synchronous, active low; empties the ring and restores the quota,
//   slot contents are not cleared (valid bits cover them).
`timescale 1ns / 1ps
`include "batch_recoder_ring_buffer_core_macros.svh"
module batch_recoder_ring_buffer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [brrb_pkg::ID_W-1:0]     in_batch_id,
  // result channel
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [brrb_pkg::SLOT_W-1:0]   out_slot,
  output logic [brrb_pkg::ID_W-1:0]     out_send_batch_id,
  output logic                          out_last,
  // quota register
  input  logic                          cfg_wr_en,
  input  logic [brrb_pkg::SENT_W-1:0]   cfg_wr_data
);

  brrb_pkg::dp_status_t st;
  brrb_pkg::op_t        op;

  // sequencer: decodes requests and steps the scans
  brrb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .st      (st),
    .busy    (busy),
    .op      (op)
  );

  // pointers, slot store and result register
  brrb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .in_batch_id       (in_batch_id),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .st                (st),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_send_batch_id (out_send_batch_id),
    .out_last          (out_last)
  );

  // a receive either answers at once or goes busy for the read-back cycle
  `BRRB_ASSERT_NXT(a_rx_answer, clk, rst_n, start && !busy && !in_kind, out_strobe != busy)
  // only member results can be followed by more results of the same request
  `BRRB_ASSERT_IMP(a_single_final, clk, rst_n, out_strobe && (out_status != brrb_pkg::ST_MEMBER), out_last)
  // with an empty ring every request is done without the block going busy
  `BRRB_ASSERT_NXT(a_empty_quick, clk, rst_n, !st.have_batch && !busy, !busy)

endmodule

@@ hw/rtl/brrb_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module brrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/brrb_ctrl.sv @@
// sequencer of the batch recoder ring buffer
`timescale 1ns / 1ps
module brrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_kind,
  input  brrb_pkg::dp_status_t   st,
  output logic                   busy,
  output brrb_pkg::op_t          op
);

  brrb_pkg::state_t state_r;
  brrb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brrb_pkg::S_IDLE: begin
        if (start && in_kind && st.have_batch && st.quota_met && st.mixed) begin
          state_nxt = brrb_pkg::S_SW;
        end else if (start && in_kind && st.have_batch && !st.quota_met) begin
          state_nxt = brrb_pkg::S_LS;
        end else if (start && !in_kind && st.have_batch && st.ring_full) begin
          state_nxt = brrb_pkg::S_RX_CHK;
        end
      end
      brrb_pkg::S_RX_CHK: state_nxt = brrb_pkg::S_IDLE;
      brrb_pkg::S_SW: begin
        if (st.sw_exit) begin
          state_nxt = brrb_pkg::S_LS_INIT;
        end
      end
      brrb_pkg::S_LS_INIT: state_nxt = brrb_pkg::S_LS;
      brrb_pkg::S_LS: begin
        if (st.ls_end) begin
          state_nxt = brrb_pkg::S_LS_FIN;
        end
      end
      brrb_pkg::S_LS_FIN: state_nxt = brrb_pkg::S_IDLE;
      default: state_nxt = brrb_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    op   = brrb_pkg::OP_NONE;
    busy = 1'b1;
    case (state_r)
      brrb_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!in_kind) begin
            if (!st.have_batch) begin
              op = brrb_pkg::OP_RX_FIRST;
            end else if (st.ring_full) begin
              op = brrb_pkg::OP_RX_FULL;
            end else begin
              op = brrb_pkg::OP_RX_PLAIN;
            end
          end else begin
            if (!st.have_batch || (st.quota_met && !st.mixed)) begin
              op = brrb_pkg::OP_REFUSE;
            end else if (st.quota_met) begin
              op = brrb_pkg::OP_SW_START;
            end else begin
              op = brrb_pkg::OP_LS_START;
            end
          end
        end
      end
      brrb_pkg::S_RX_CHK:  op = brrb_pkg::OP_RX_CHK;
      brrb_pkg::S_SW:      op = brrb_pkg::OP_SW_STEP;
      brrb_pkg::S_LS_INIT: op = brrb_pkg::OP_LS_START;
      brrb_pkg::S_LS:      op = brrb_pkg::OP_LS_STEP;
      brrb_pkg::S_LS_FIN:  op = brrb_pkg::OP_LS_FIN;
      default: begin
        op   = brrb_pkg::OP_NONE;
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/brrb_dp.sv @@
// ring pointers, slot store, scan logic and result register
`timescale 1ns / 1ps
module brrb_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  brrb_pkg::op_t                      op,
  input  logic [brrb_pkg::ID_W-1:0]          in_batch_id,
  input  logic                               cfg_wr_en,
  input  logic [brrb_pkg::SENT_W-1:0]        cfg_wr_data,
  output brrb_pkg::dp_status_t               st,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic [brrb_pkg::SLOT_W-1:0]        out_slot,
  output logic [brrb_pkg::ID_W-1:0]          out_send_batch_id,
  output logic                               out_last
);

  // architectural state
  logic [brrb_pkg::IDX_W-1:0]  send_first_r, send_first_nxt;
  logic [brrb_pkg::IDX_W-1:0]  recv_last_r, recv_last_nxt;
  logic [brrb_pkg::ID_W-1:0]   send_batch_r, send_batch_nxt;
  logic                        have_batch_r, have_batch_nxt;
  logic [brrb_pkg::SENT_W-1:0] sent_count_r, sent_count_nxt;
  logic                        mixed_r, mixed_nxt;
  logic [brrb_pkg::DEPTH-1:0]  valid_r, valid_nxt;
  logic [brrb_pkg::SENT_W-1:0] quota_r, quota_nxt;

  // scan state
  logic [brrb_pkg::CNT_W-1:0]  iss_r, iss_nxt;
  logic                        rd_live_r, rd_live_nxt;
  logic [brrb_pkg::IDX_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [brrb_pkg::HIT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic                        hold_vld_r, hold_vld_nxt;
  logic [brrb_pkg::IDX_W-1:0]  hold_pos_r, hold_pos_nxt;

  // result register
  logic                        out_strobe_r, out_strobe_nxt;
  brrb_pkg::status_t           out_status_r, out_status_nxt;
  logic [brrb_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [brrb_pkg::ID_W-1:0]   out_batch_r, out_batch_nxt;
  logic                        out_last_r, out_last_nxt;

  // slot store
  logic                        ram_we;
  logic [brrb_pkg::IDX_W-1:0]  ram_waddr;
  logic [brrb_pkg::ID_W-1:0]   ram_wdata;
  logic [brrb_pkg::IDX_W-1:0]  ram_raddr;
  logic [brrb_pkg::ID_W-1:0]   ram_rdata;

  logic [brrb_pkg::IDX_W-1:0]  recv_next;
  logic [brrb_pkg::IDX_W-1:0]  send_next;
  logic [brrb_pkg::IDX_W-1:0]  iss_addr;
  logic                        slot_ok;
  logic                        hit_same;
  logic                        hit_other;

  brrb_ram #(
    .WIDTH (brrb_pkg::ID_W),
    .DEPTH (brrb_pkg::DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign recv_next = brrb_pkg::ring_add(recv_last_r, brrb_pkg::CNT_W'(1));
  assign send_next = brrb_pkg::ring_add(send_first_r, brrb_pkg::CNT_W'(1));
  assign iss_addr  = brrb_pkg::ring_add(send_first_r, iss_r);
  assign slot_ok   = rd_live_r && valid_r[rd_pos_r];
  assign hit_same  = slot_ok && (ram_rdata == send_batch_r);
  assign hit_other = slot_ok && (ram_rdata != send_batch_r);

  assign st.have_batch = have_batch_r;
  assign st.ring_full  = (recv_next == send_first_r);
  assign st.quota_met  = (sent_count_r >= quota_r);
  assign st.mixed      = mixed_r;
  assign st.sw_exit    = rd_live_r &&
                         (hit_other || (iss_r == brrb_pkg::CNT_W'(brrb_pkg::DEPTH)));
  assign st.ls_end     = rd_live_r &&
                         (!hit_same ||
                          (hit_cnt_r == brrb_pkg::HIT_W'(brrb_pkg::LIST_MAX - 1)));

  always_comb begin
    send_first_nxt = send_first_r;
    recv_last_nxt  = recv_last_r;
    send_batch_nxt = send_batch_r;
    have_batch_nxt = have_batch_r;
    sent_count_nxt = sent_count_r;
    mixed_nxt      = mixed_r;
    valid_nxt      = valid_r;
    quota_nxt      = cfg_wr_en ? cfg_wr_data : quota_r;
    iss_nxt        = iss_r;
    rd_live_nxt    = rd_live_r;
    rd_pos_nxt     = rd_pos_r;
    hit_cnt_nxt    = hit_cnt_r;
    hold_vld_nxt   = hold_vld_r;
    hold_pos_nxt   = hold_pos_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = brrb_pkg::ST_STORED;
    out_slot_nxt   = brrb_pkg::to_slot(send_first_r);
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = recv_next;
    ram_wdata      = in_batch_id;
    ram_raddr      = send_first_r;

    case (op)
      brrb_pkg::OP_RX_FIRST: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        valid_nxt[0]   = 1'b1;
        recv_last_nxt  = '0;
        send_first_nxt = '0;
        send_batch_nxt = in_batch_id;
        have_batch_nxt = 1'b1;
        out_strobe_nxt = 1'b1;
        out_slot_nxt   = brrb_pkg::to_slot('0);
      end
      brrb_pkg::OP_RX_PLAIN: begin
        ram_we               = 1'b1;
        ram_waddr            = recv_next;
        valid_nxt[recv_next] = 1'b1;
        recv_last_nxt        = recv_next;
        mixed_nxt            = mixed_r || (in_batch_id != send_batch_r);
        out_strobe_nxt       = 1'b1;
        out_slot_nxt         = brrb_pkg::to_slot(recv_next);
      end
      brrb_pkg::OP_RX_FULL: begin
        // overwrite the oldest slot, fetch the slot behind it
        ram_we                  = 1'b1;
        ram_waddr               = send_first_r;
        valid_nxt[send_first_r] = 1'b1;
        recv_last_nxt           = send_first_r;
        send_first_nxt          = send_next;
        ram_raddr               = send_next;
        mixed_nxt               = mixed_r || (in_batch_id != send_batch_r);
      end
      brrb_pkg::OP_RX_CHK: begin
        if (ram_rdata != send_batch_r) begin
          send_batch_nxt = ram_rdata;
          sent_count_nxt = '0;
          mixed_nxt      = 1'b0;
        end
        out_strobe_nxt = 1'b1;
        out_slot_nxt   = brrb_pkg::to_slot(recv_last_r);
      end
      brrb_pkg::OP_REFUSE: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = brrb_pkg::ST_REFUSED;
      end
      brrb_pkg::OP_SW_START, brrb_pkg::OP_LS_START: begin
        ram_raddr    = send_first_r;
        rd_live_nxt  = 1'b1;
        rd_pos_nxt   = send_first_r;
        iss_nxt      = brrb_pkg::CNT_W'(1);
        hit_cnt_nxt  = '0;
        hold_vld_nxt = 1'b0;
      end
      brrb_pkg::OP_SW_STEP: begin
        if (iss_r < brrb_pkg::CNT_W'(brrb_pkg::DEPTH)) begin
          ram_raddr   = iss_addr;
          rd_live_nxt = 1'b1;
          rd_pos_nxt  = iss_addr;
          iss_nxt     = iss_r + brrb_pkg::CNT_W'(1);
        end else begin
          rd_live_nxt = 1'b0;
        end
        if (hit_other) begin
          send_batch_nxt = ram_rdata;
          send_first_nxt = rd_pos_r;
          sent_count_nxt = '0;
        end
        if (st.sw_exit) begin
          mixed_nxt   = 1'b0;
          rd_live_nxt = 1'b0;
        end
      end
      brrb_pkg::OP_LS_STEP: begin
        if (iss_r < brrb_pkg::CNT_W'(brrb_pkg::LIST_MAX)) begin
          ram_raddr   = iss_addr;
          rd_live_nxt = 1'b1;
          rd_pos_nxt  = iss_addr;
          iss_nxt     = iss_r + brrb_pkg::CNT_W'(1);
        end else begin
          rd_live_nxt = 1'b0;
        end
        // one member is held back until we know whether it is the final one
        if (hit_same) begin
          out_strobe_nxt = hold_vld_r;
          out_status_nxt = brrb_pkg::ST_MEMBER;
          out_slot_nxt   = brrb_pkg::to_slot(hold_pos_r);
          out_last_nxt   = 1'b0;
          hold_vld_nxt   = 1'b1;
          hold_pos_nxt   = rd_pos_r;
          hit_cnt_nxt    = hit_cnt_r + brrb_pkg::HIT_W'(1);
        end
        if (st.ls_end) begin
          rd_live_nxt = 1'b0;
        end
      end
      brrb_pkg::OP_LS_FIN: begin
        out_strobe_nxt = 1'b1;
        if (hold_vld_r) begin
          out_status_nxt = brrb_pkg::ST_MEMBER;
          out_slot_nxt   = brrb_pkg::to_slot(hold_pos_r);
        end else begin
          out_status_nxt = brrb_pkg::ST_EMPTY;
        end
        if (sent_count_r != brrb_pkg::SENT_MAX) begin
          sent_count_nxt = sent_count_r + brrb_pkg::SENT_W'(1);
        end
        hold_vld_nxt = 1'b0;
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase

    out_batch_nxt = send_batch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_first_r <= '0;
      recv_last_r  <= '0;
      send_batch_r <= '0;
      have_batch_r <= 1'b0;
      sent_count_r <= '0;
      mixed_r      <= 1'b0;
      valid_r      <= '0;
      quota_r      <= brrb_pkg::QUOTA_RESET;
      iss_r        <= '0;
      rd_live_r    <= 1'b0;
      hit_cnt_r    <= '0;
      hold_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      send_first_r <= send_first_nxt;
      recv_last_r  <= recv_last_nxt;
      send_batch_r <= send_batch_nxt;
      have_batch_r <= have_batch_nxt;
      sent_count_r <= sent_count_nxt;
      mixed_r      <= mixed_nxt;
      valid_r      <= valid_nxt;
      quota_r      <= quota_nxt;
      iss_r        <= iss_nxt;
      rd_live_r    <= rd_live_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r     <= rd_pos_nxt;
    hold_pos_r   <= hold_pos_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_batch_r  <= out_batch_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_send_batch_id = out_batch_r;
  assign out_last          = out_last_r;

endmodule

@@ tb/batch_recoder_ring_buffer_core_test.sv @@
// self-checking testbench of the batch recoder ring buffer core: slot ring prediction
`timescale 1ns / 1ps
module batch_recoder_ring_buffer_core_test;
  import brrb_pkg::*;

  // request kinds on in_kind
  localparam bit KIND_RECEIVE = 1'b0;
  localparam bit KIND_RECODE  = 1'b1;

  localparam int TAIL_RUNS = 18;  // recodes in a row at the end of the run

  typedef struct {
    bit              kind;
    logic [ID_W-1:0] batch_id;
  } ring_req_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   send_batch_id;
    logic              last;
  } slot_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_kind = 1'b0;
  logic [ID_W-1:0]     in_batch_id = '0;
  logic                out_strobe;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [ID_W-1:0]     out_send_batch_id;
  logic                out_last;
  logic                cfg_wr_en = 1'b0;
  logic [SENT_W-1:0]   cfg_wr_data = '0;

  batch_recoder_ring_buffer_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_batch_id       (in_batch_id),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_send_batch_id (out_send_batch_id),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: the slowest correct run is far below this
  initial begin
    #2000000;
    $display("FAIL batch_recoder_ring_buffer_core");
    $finish;
  end

  // ------------------------------------------------------------------------
  // shadow of the slot ring; it moves once per accepted request
  // ------------------------------------------------------------------------
  logic [ID_W-1:0]   ring_batch [DEPTH];
  bit                ring_valid [DEPTH];
  int                send_head;      // oldest slot of the batch being sent
  int                recv_tail;      // slot of the newest received packet
  logic [ID_W-1:0]   cur_batch;      // batch being sent
  bit                ring_loaded;    // at least one packet held
  logic [SENT_W-1:0] sent_runs;      // recodes sent for cur_batch, saturating
  bit                mixed_seen;     // another batch arrived while sending
  logic [SENT_W-1:0] quota_cfg = QUOTA_RESET;

  slot_report_t      due_reports[$]; // results still owed by the block
  ring_req_t         req_queue[$];   // requests not yet handed to the driver
  int                reqs_queued = 0;
  int                reqs_taken = 0;
  int                mismatches = 0;

  task automatic post_report(input status_t st, input int pos, input bit fin);
    slot_report_t r;
    r.status        = st;
    r.slot          = SLOT_W'(pos);
    r.send_batch_id = cur_batch;
    r.last          = fin;
    due_reports.push_back(r);
  endtask

  task automatic advance_ring(input bit kind, input logic [ID_W-1:0] id);
    int  i;
    int  p;
    int  n;
    int  nh;
    bit  met;
    bit  hit;
    if (kind == KIND_RECEIVE) begin
      if (!ring_loaded) begin
        // first packet ever: ring restarts at slot 0, mixed flag untouched
        send_head     = 0;
        recv_tail     = 0;
        cur_batch     = id;
        ring_batch[0] = id;
        ring_valid[0] = 1'b1;
        ring_loaded   = 1'b1;
        post_report(ST_STORED, 0, 1'b1);
      end else begin
        if (id != cur_batch) begin
          mixed_seen = 1'b1;
        end
        if ((recv_tail + 1) % DEPTH == send_head) begin
          // ring full: overwrite the oldest slot, send batch follows the new head
          nh            = (send_head + 1) % DEPTH;
          p             = send_head;
          ring_batch[p] = id;
          ring_valid[p] = 1'b1;
          recv_tail     = p;
          send_head     = nh;
          if (ring_batch[nh] != cur_batch) begin
            cur_batch  = ring_batch[nh];
            sent_runs  = '0;
            mixed_seen = 1'b0;
          end
        end else begin
          p             = (recv_tail + 1) % DEPTH;
          ring_batch[p] = id;
          ring_valid[p] = 1'b1;
          recv_tail     = p;
        end
        post_report(ST_STORED, p, 1'b1);
      end
    end else if (!ring_loaded) begin
      post_report(ST_REFUSED, 0, 1'b1);
    end else begin
      met = (sent_runs >= quota_cfg);
      if (met && !mixed_seen) begin
        post_report(ST_REFUSED, send_head, 1'b1);
      end else begin
        if (met) begin
          // quota done and others waiting: move on to the next batch in ring order
          hit = 1'b0;
          for (i = 0; i < DEPTH; i++) begin
            p = (send_head + i) % DEPTH;
            if (!hit && ring_valid[p] && ring_batch[p] != cur_batch) begin
              cur_batch = ring_batch[p];
              send_head = p;
              sent_runs = '0;
              hit       = 1'b1;
            end
          end
          mixed_seen = 1'b0;
        end
        // adjacent members of the send batch, capped per run
        n   = 0;
        hit = 1'b0;
        for (i = 0; i < DEPTH && i < MAX_RES; i++) begin
          p = (send_head + i) % DEPTH;
          if (hit || !ring_valid[p] || ring_batch[p] != cur_batch) begin
            hit = 1'b1;
          end else begin
            n++;
          end
        end
        if (sent_runs != SENT_MAX) begin
          sent_runs = sent_runs + 1'b1;
        end
        if (n == 0) begin
          post_report(ST_EMPTY, send_head, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            post_report(ST_MEMBER, (send_head + i) % DEPTH, i == n - 1);
          end
        end
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps between them
  // ------------------------------------------------------------------------
  int        burst_left = 1;
  int        gap_left = 0;
  ring_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // a held request is taken at this edge; predict it before moving on
      if (start) begin
        advance_ring(in_kind, in_batch_id);
        reqs_taken++;
      end
      if (gap_left > 0 || req_queue.size() == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end
        start <= 1'b0;
      end else begin
        next_req = req_queue.pop_front();
        in_kind     <= next_req.kind;
        in_batch_id <= next_req.batch_id;
        start       <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // now and then a long stretch back to back
          if ($urandom_range(0, 3) == 0) begin
            burst_left = 24;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor: no backpressure, every strobe is a result
  // ------------------------------------------------------------------------
  slot_report_t want;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result: status %0d slot %0d send_batch_id %0h last %0b",
               out_status, out_slot, out_send_batch_id, out_last);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (out_status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_slot != want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, out_slot);
          mismatches++;
        end
        if (out_send_batch_id != want.send_batch_id) begin
          $error("send_batch_id: expected %0h, actual %0h",
                 want.send_batch_id, out_send_batch_id);
          mismatches++;
        end
        if (out_last != want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  logic [ID_W-1:0] traffic_batch;

  task automatic queue_request(input bit kind, input logic [ID_W-1:0] id);
    ring_req_t r;
    r.kind     = kind;
    r.batch_id = id;
    req_queue.push_back(r);
    reqs_queued++;
  endtask

  // block idle: every request taken, every result seen, no run in flight
  task automatic drain_ring();
    while (reqs_taken != reqs_queued || due_reports.size() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  task automatic write_quota(input logic [SENT_W-1:0] q);
    drain_ring();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    quota_cfg    = q;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly batches arriving in order with recodes mixed in, some stragglers
  // from the previous batch and some stray batch numbers
  task automatic queue_traffic(input int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        queue_request(KIND_RECODE, ID_W'($urandom));
      end else if (r < 50) begin
        queue_request(KIND_RECEIVE, ID_W'($urandom));
      end else if (r < 56) begin
        queue_request(KIND_RECEIVE, traffic_batch - 1'b1);
      end else begin
        queue_request(KIND_RECEIVE, traffic_batch);
        if ($urandom_range(0, 5) == 0) begin
          traffic_batch = traffic_batch + 1'b1;
        end
      end
    end
  endtask

  initial begin
    int i;
    int ph;
    for (i = 0; i < DEPTH; i++) begin
      ring_batch[i] = '0;
      ring_valid[i] = 1'b0;
    end
    send_head     = 0;
    recv_tail     = 0;
    cur_batch     = '0;
    ring_loaded   = 1'b0;
    sent_runs     = '0;
    mixed_seen    = 1'b0;
    traffic_batch = ID_W'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset quota of 16: recode on an empty ring, then a ring
    // filled by one batch whose recode hits the per-run listing cap
    queue_request(KIND_RECODE, 16'h0000);
    for (i = 0; i < DEPTH; i++) begin
      queue_request(KIND_RECEIVE, 16'hFFFF);
    end
    queue_request(KIND_RECODE, 16'hFFFF);
    // full ring overwrite by another batch sets the mixed flag
    queue_request(KIND_RECEIVE, 16'h0000);
    queue_request(KIND_RECODE, 16'h5555);

    // quota of one: switch to the waiting batch, then a refusal with no new
    // batch since the switch, then a new batch and another switch
    write_quota(8'd1);
    queue_request(KIND_RECODE, 16'hAAAA);
    queue_request(KIND_RECODE, 16'h0000);
    queue_request(KIND_RECEIVE, 16'h5555);
    queue_request(KIND_RECODE, 16'h0000);

    // random traffic over a spread of quotas, extremes first
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_quota(8'd0);
        1: write_quota(8'd255);
        2: write_quota(8'd1);
        3: write_quota(8'd2);
        4: write_quota(8'd3);
        default: write_quota(SENT_W'($urandom_range(4, 20)));
      endcase
      queue_traffic(13);
    end

    // closing recode series at the top quota with no new packets: the same
    // batch is listed run after run
    write_quota(8'd255);
    for (i = 0; i < TAIL_RUNS; i++) begin
      queue_request(KIND_RECODE, ID_W'($urandom));
    end

    drain_ring();
    // catch stray results after the last one owed
    repeat (3 * DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS batch_recoder_ring_buffer_core");
    end else begin
      $display("FAIL batch_recoder_ring_buffer_core");
    end
    $finish;
  end

endmodule
